// File: rtl/sgm_pkg.sv
// sgm_pkg: shared types and constants of the sobel gradient magnitude unit
// no dependencies; used by the interfaces and by every rtl module but sgm_ram

package sgm_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam int CFG_DATA_W = 13;
  localparam int FRAME_WIDTH_W = 11;
  localparam int FRAME_HEIGHT_W = 13;

  localparam logic [10:0] FRAME_WIDTH_RESET = 11'd1024;
  localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd768;
  localparam logic [12:0] MAX_ROWS = 13'd4096;
  localparam int MIN_FRAME_SIZE = 3;

  // field widths of a result and of a gradient item
  localparam int COL_W = 10;
  localparam int ROW_W = 12;
  localparam int MAG_W = 8;
  localparam int GRAD_W = 11;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QLEVEL_W = $clog2(QUEUE_DEPTH + 1);

  // square root: one result bit per step
  localparam int ROOT_STEPS = MAG_W;
  localparam int STEP_W = $clog2(ROOT_STEPS);
  localparam logic [20:0] SAT_LIMIT = 21'd65280;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // one interior pixel handed from front to back
  typedef struct packed {
    logic [COL_W-1:0]         column;
    logic [ROW_W-1:0]         row;
    logic                     done;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } grad_item_t;

endpackage

// File: rtl/sgm_if.sv
// sgm_if: valid/ready channel interfaces of the sobel gradient magnitude unit
// depends on sgm_pkg

interface sgm_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic       start_of_frame;

  modport source (output valid, output pixel_value, output start_of_frame, input ready);
  modport sink (input valid, input pixel_value, input start_of_frame, output ready);
endinterface

interface sgm_result_if;
  logic                         valid;
  logic                         ready;
  logic [sgm_pkg::COL_W-1:0]    out_column;
  logic [sgm_pkg::ROW_W-1:0]    out_row;
  logic [sgm_pkg::MAG_W-1:0]    magnitude;
  logic                         frame_done;

  modport source (output valid, output out_column, output out_row, output magnitude,
                  output frame_done, input ready);
  modport sink (input valid, input out_column, input out_row, input magnitude,
                input frame_done, output ready);
endinterface

interface sgm_cfg_if;
  logic                           valid;
  logic                           ready;
  sgm_pkg::cfg_reg_t              index;
  logic [sgm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/sgm_ram.sv
// sgm_ram: generic single write port, single read port ram with registered read
// no dependencies

module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sgm_front.sv
// sgm_front: position counters, two line stores, 3x3 window and sobel sums
// depends on sgm_pkg, sgm_if, sgm_ram

module sgm_front #(
  parameter int MAX_LINE_PIXELS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  sgm_pixel_if.sink                      pixel,
  input  logic [sgm_pkg::FRAME_WIDTH_W-1:0]  frame_width,
  input  logic [sgm_pkg::FRAME_HEIGHT_W-1:0] frame_height,
  input  logic [sgm_pkg::QLEVEL_W-1:0]   q_level,
  output logic                           push,
  output sgm_pkg::grad_item_t            push_item
);

  localparam int CW = $clog2(MAX_LINE_PIXELS);
  localparam int WW = CW + 1;
  localparam int HW = sgm_pkg::FRAME_HEIGHT_W;
  localparam int RW = sgm_pkg::ROW_W;

  function automatic logic [9:0] wsum(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    wsum = 10'(a) + {1'b0, b, 1'b0} + 10'(c);
  endfunction

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic          accept;
  logic [CW-1:0] xs;
  logic [RW-1:0] ys;
  logic [CW-1:0] column, column_next;
  logic [RW-1:0] row, row_next;
  logic          emit, done;

  // stage a: item whose line store reads are in flight
  logic          a_valid;
  logic [CW-1:0] a_x;
  logic [RW-1:0] a_y;
  logic [7:0]    a_pix;
  logic          a_emit, a_done, a_hit;
  logic [7:0]    a_fwd_top, a_fwd_mid;

  logic [7:0]    up_rdata, mid_rdata;
  logic [7:0]    b_top, b_mid;
  logic [7:0]    win [6];
  logic [9:0]    gx_pos, gx_neg, gy_pos, gy_neg;

  // clamp sizes
  always_comb begin
    if (32'(frame_width) > MAX_LINE_PIXELS) begin
      eff_w = WW'(MAX_LINE_PIXELS);
    end else if (32'(frame_width) < sgm_pkg::MIN_FRAME_SIZE) begin
      eff_w = WW'(sgm_pkg::MIN_FRAME_SIZE);
    end else begin
      eff_w = WW'(frame_width);
    end
    if (frame_height > sgm_pkg::MAX_ROWS) begin
      eff_h = sgm_pkg::MAX_ROWS;
    end else if (32'(frame_height) < sgm_pkg::MIN_FRAME_SIZE) begin
      eff_h = HW'(sgm_pkg::MIN_FRAME_SIZE);
    end else begin
      eff_h = frame_height;
    end
  end

  // room for this item and the one in stage a
  assign pixel.ready = (4'(q_level) + 4'(a_valid)) < 4'(sgm_pkg::QUEUE_DEPTH);
  assign accept = pixel.valid && pixel.ready;

  assign xs = pixel.start_of_frame ? '0 : column;
  assign ys = pixel.start_of_frame ? '0 : row;

  always_comb begin
    column_next = xs + CW'(1);
    row_next = ys;
    if (WW'(xs) + WW'(1) >= eff_w) begin
      column_next = '0;
      row_next = (HW'(ys) + HW'(1) >= eff_h) ? '0 : ys + RW'(1);
    end
  end

  assign emit = (xs >= CW'(2)) && (ys >= RW'(2)) && (WW'(xs) < eff_w) && (HW'(ys) < eff_h);
  assign done = (WW'(xs) == eff_w - WW'(1)) && (HW'(ys) == eff_h - HW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row <= '0;
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        column <= column_next;
        row <= row_next;
      end
    end
  end

  // same column read and written at one edge (back to back start of frame)
  always_ff @(posedge clk) begin
    if (accept) begin
      a_x <= xs;
      a_y <= ys;
      a_pix <= pixel.pixel_value;
      a_emit <= emit;
      a_done <= done;
      a_hit <= a_valid && (a_x == xs);
      a_fwd_top <= b_mid;
      a_fwd_mid <= a_pix;
    end
  end

  sgm_ram #(.WIDTH(8), .DEPTH(MAX_LINE_PIXELS)) u_upper (
    .clk   (clk),
    .we    (a_valid),
    .waddr (a_x),
    .wdata (b_mid),
    .re    (accept),
    .raddr (xs),
    .rdata (up_rdata)
  );

  sgm_ram #(.WIDTH(8), .DEPTH(MAX_LINE_PIXELS)) u_middle (
    .clk   (clk),
    .we    (a_valid),
    .waddr (a_x),
    .wdata (a_pix),
    .re    (accept),
    .raddr (xs),
    .rdata (mid_rdata)
  );

  assign b_top = a_hit ? a_fwd_top : up_rdata;
  assign b_mid = a_hit ? a_fwd_mid : mid_rdata;

  // window: 0..2 column x-2, 3..5 column x-1, rows top/middle/bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (a_valid) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= b_top;
      win[4] <= b_mid;
      win[5] <= a_pix;
    end
  end

  assign gx_pos = wsum(b_top, b_mid, a_pix);
  assign gx_neg = wsum(win[0], win[1], win[2]);
  assign gy_pos = wsum(win[0], win[3], b_top);
  assign gy_neg = wsum(win[2], win[5], a_pix);

  assign push = a_valid && a_emit;
  always_comb begin
    push_item.column = sgm_pkg::COL_W'(a_x - CW'(1));
    push_item.row = a_y - RW'(1);
    push_item.done = a_done;
    push_item.gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    push_item.gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
  end

endmodule

// File: rtl/sgm_queue.sv
// sgm_queue: short fifo of gradient items between front and back
// depends on sgm_pkg

module sgm_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  sgm_pkg::grad_item_t          push_item,
  input  logic                         pop,
  output sgm_pkg::grad_item_t          head,
  output logic                         empty,
  output logic [sgm_pkg::QLEVEL_W-1:0] level
);

  sgm_pkg::grad_item_t          entries [sgm_pkg::QUEUE_DEPTH];
  logic [sgm_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;

  assign head = entries[rd_ptr];
  assign empty = (level == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/sgm_back.sv
// sgm_back: squares, sum and rounded square root of one gradient item at a time
// depends on sgm_pkg, sgm_if

module sgm_back (
  input  logic                clk,
  input  logic                rst,
  input  sgm_pkg::grad_item_t head,
  input  logic                empty,
  output logic                pop,
  sgm_result_if.source        result
);

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_SQUARE = 5'b00010,
    B_SUM    = 5'b00100,
    B_ROOT   = 5'b01000,
    B_FINISH = 5'b10000
  } back_state_t;

  back_state_t state, state_next;

  logic [sgm_pkg::COL_W-1:0]  column;
  logic [sgm_pkg::ROW_W-1:0]  row;
  logic                       done;
  logic [9:0]                 ax, ay;
  logic [19:0]                sqx, sqy;
  logic [20:0]                sum;
  logic                       sat;
  logic [15:0]                rad;
  logic [7:0]                 root;
  logic [8:0]                 rem;
  logic [sgm_pkg::STEP_W-1:0] step;
  logic [10:0]                rem_sh;
  logic [9:0]                 trial;
  logic                       take;
  logic                       out_free;
  logic [sgm_pkg::MAG_W-1:0]  mag;

  logic                       out_valid;
  logic [sgm_pkg::COL_W-1:0]  out_column;
  logic [sgm_pkg::ROW_W-1:0]  out_row;
  logic [sgm_pkg::MAG_W-1:0]  out_mag;
  logic                       out_done;

  assign pop = (state == B_IDLE) && !empty;
  assign sum = {1'b0, sqx} + {1'b0, sqy};
  assign rem_sh = {rem, rad[15:14]};
  assign trial = {root, 2'b01};
  assign take = rem_sh >= {1'b0, trial};
  assign out_free = !out_valid || result.ready;

  // saturate above the limit, else round up where the remainder passes the floor root
  always_comb begin
    if (sat) begin
      mag = sgm_pkg::MAG_MAX;
    end else if ((rem > {1'b0, root}) && (root != sgm_pkg::MAG_MAX)) begin
      mag = root + 1'b1;
    end else begin
      mag = root;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (!empty) state_next = B_SQUARE;
      B_SQUARE: state_next = B_SUM;
      B_SUM:    state_next = B_ROOT;
      B_ROOT:   if (step == sgm_pkg::STEP_W'(sgm_pkg::ROOT_STEPS - 1)) state_next = B_FINISH;
      B_FINISH: if (out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        column <= head.column;
        row <= head.row;
        done <= head.done;
        ax <= head.gx[10] ? 10'(-head.gx) : head.gx[9:0];
        ay <= head.gy[10] ? 10'(-head.gy) : head.gy[9:0];
      end
      B_SQUARE: begin
        sqx <= 20'(ax) * 20'(ax);
        sqy <= 20'(ay) * 20'(ay);
      end
      B_SUM: begin
        sat <= sum > sgm_pkg::SAT_LIMIT;
        rad <= sum[15:0];
        root <= '0;
        rem <= '0;
        step <= '0;
      end
      B_ROOT: begin
        rad <= {rad[13:0], 2'b00};
        step <= step + 1'b1;
        if (take) begin
          rem <= 9'(rem_sh - {1'b0, trial});
          root <= {root[6:0], 1'b1};
        end else begin
          rem <= rem_sh[8:0];
          root <= {root[6:0], 1'b0};
        end
      end
      B_FINISH: begin
        if (out_free) begin
          out_column <= column;
          out_row <= row;
          out_mag <= mag;
          out_done <= done;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.valid = out_valid;
  assign result.out_column = out_column;
  assign result.out_row = out_row;
  assign result.magnitude = out_mag;
  assign result.frame_done = out_done;

endmodule

// File: rtl/sobel_gradient_magnitude_unit.sv
// sobel_gradient_magnitude_unit: top level, 3x3 sobel edge magnitude on a pixel stream
// depends on sgm_pkg, sgm_if, sgm_ram, sgm_front, sgm_queue, sgm_back
//
//   channel  dir  handshake     carries
//   pixel    in   valid/ready   pixel_value, start_of_frame
//   result   out  valid/ready   out_column, out_row, magnitude, frame_done
//   cfg      in   valid/ready   index (frame_width, frame_height), data
//
// pixels that give no result go through at one per cycle while the queue has room
// an interior pixel passes the back end in order: pop, square, sum, 8 root
//   steps (one result bit each) and the output load, which waits for a free output register
// a four-entry queue lets the front keep taking pixels while the back works
// result stalls hold the output register; the front stops once the queue entries
//   plus the request in its read stage reach four
// synchronous reset clears counters, window, queue and control; line stores are not cleared

module sobel_gradient_magnitude_unit #(
  parameter int MAX_LINE_PIXELS = 1024
) (
  input  logic          clk,
  input  logic          rst,
  sgm_pixel_if.sink     pixel,
  sgm_result_if.source  result,
  sgm_cfg_if.sink       cfg
);

  // configuration registers
  logic [sgm_pkg::FRAME_WIDTH_W-1:0]  frame_width;
  logic [sgm_pkg::FRAME_HEIGHT_W-1:0] frame_height;

  // front to back queue
  logic                         push;
  sgm_pkg::grad_item_t          push_item;
  logic                         pop;
  sgm_pkg::grad_item_t          head;
  logic                         empty;
  logic [sgm_pkg::QLEVEL_W-1:0] q_level;

  // writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= sgm_pkg::FRAME_WIDTH_RESET;
      frame_height <= sgm_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        sgm_pkg::REG_FRAME_WIDTH:  frame_width <= cfg.data[sgm_pkg::FRAME_WIDTH_W-1:0];
        sgm_pkg::REG_FRAME_HEIGHT: frame_height <= cfg.data[sgm_pkg::FRAME_HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: counters, line stores, window, sobel sums
  sgm_front #(.MAX_LINE_PIXELS(MAX_LINE_PIXELS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .pixel        (pixel),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .q_level      (q_level),
    .push         (push),
    .push_item    (push_item)
  );

  // queue: decouples front from back
  sgm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .level     (q_level)
  );

  // back: magnitude and output register
  sgm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

`ifndef SYNTH
  // queue never holds more than its depth
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= sgm_pkg::QLEVEL_W'(sgm_pkg::QUEUE_DEPTH))
    else $error("queue level above depth");

  // front never pushes into a full queue that is not drained the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && (q_level == sgm_pkg::QLEVEL_W'(sgm_pkg::QUEUE_DEPTH)) |-> pop)
    else $error("push into full queue");

  // back only pops a filled queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  // a push with no pop raises the level by one
  a_level_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> q_level == $past(q_level) + 1'b1)
    else $error("queue level did not follow push");
`endif

endmodule
